// ===== rtl/rnpb_pkg.sv =====
// package: shared constants and payload types for the neighbour pair builder
`timescale 1ns / 1ps
`default_nettype none
package rnpb_pkg;
  localparam int MaxPointsDefault = 64;
  localparam int CoordBitsDefault = 16;
  localparam int FieldBits = 16;
  localparam int RowBits = 64;
  localparam int IdxBits = 6;
  localparam int CapBits = 6;
  localparam int AddrBits = 4;

  localparam logic [1:0] RegRadius = 2'd0;
  localparam logic [1:0] RegMaxPartners = 2'd1;
  localparam logic [1:0] RegAcross = 2'd2;
  localparam logic [1:0] RegLane = 2'd3;

  typedef struct packed {
    logic signed [FieldBits-1:0] x_coord;
    logic signed [FieldBits-1:0] y_coord;
    logic signed [FieldBits-1:0] z_coord;
    logic [FieldBits-1:0]        piece_id;
    logic                        final_point;
  } in_item_t;

  typedef struct packed {
    logic [IdxBits-1:0] row_index;
    logic [RowBits-1:0] partner_bits;
    logic               row_last;
    logic               overflowed;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic store;     // write incoming point at count
    logic clr_row;   // clear kept row i, start scan
    logic cand_step; // evaluate pair (i,j) for candidacy
    logic sel_clear; // start a selection pass
    logic sel_step;  // evaluate j in selection pass
    logic sel_commit;// commit best of pass
    logic use_cand;  // kept row i = candidate set
    logic emit_load; // load emit word for row i
    logic emit_step; // fold column bit for j
  } dp_cmd_t;

  typedef struct packed {
    logic have;      // selection pass found a partner
    logic [IdxBits:0] ncand;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/rnpb_datapath.sv =====
// datapath: point stores, distance unit, kept matrix, selection and row assembly
`timescale 1ns / 1ps
`default_nettype none
module rnpb_datapath
  import rnpb_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDefault,
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  wire logic                 clk,
  input  wire dp_cmd_t              cmd,
  input  wire in_item_t             in_item,
  input  wire logic [IdxBits:0]     count,
  input  wire logic [IdxBits-1:0]   idx_i,
  input  wire logic [IdxBits-1:0]   idx_j,
  input  wire logic [15:0]          radius,
  input  wire logic                 across,
  input  wire logic                 lane,
  output dp_stat_t                  stat,
  output logic [RowBits-1:0]        emit_bits
);
  localparam int DW = COORD_BITS + 1;
  localparam int SW = 2 * DW + 2;

  logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];
  logic signed [COORD_BITS-1:0] mem_z [MAX_POINTS];
  logic [FieldBits-1:0]         mem_p [MAX_POINTS];
  logic [RowBits-1:0]           kept [MAX_POINTS];

  // point i held in registers during its row
  logic signed [COORD_BITS-1:0] ax, ay, az;
  logic [FieldBits-1:0] ap;
  // point j and its kept row, read in the cycle after idx_j
  logic signed [COORD_BITS-1:0] rx, ry, rz;
  logic [FieldBits-1:0] rp;
  logic [RowBits-1:0] rk;
  logic [IdxBits-1:0] jr;
  logic [RowBits-1:0] cand, chosen, emit_r;
  logic [IdxBits:0] ncand;
  logic have;
  logic [IdxBits-1:0] best;
  logic [SW-1:0] bestd;

  logic signed [DW-1:0] dx, dy, dz;
  logic [SW-1:0] d2, r2;
  logic [RowBits-1:0] bit_j, bit_i;
  logic in_range, piece_ok;

  always_comb begin
    dx = DW'(rx) - DW'(ax);
    dy = DW'(ry) - DW'(ay);
    dz = DW'(rz) - DW'(az);
    d2 = SW'(dx * dx) + SW'(dy * dy) + SW'(dz * dz);
    r2 = SW'(radius) * SW'(radius);
    in_range = d2 <= r2;
    piece_ok = !across || (lane && rp != ap);
    bit_j = RowBits'(1) << jr;
    bit_i = RowBits'(1) << idx_i;
  end

  always_ff @(posedge clk) begin
    rx <= mem_x[idx_j];
    ry <= mem_y[idx_j];
    rz <= mem_z[idx_j];
    rp <= mem_p[idx_j];
    rk <= kept[idx_j];
    jr <= idx_j;
    if (cmd.store) begin
      mem_x[count[IdxBits-1:0]] <= in_item.x_coord[COORD_BITS-1:0];
      mem_y[count[IdxBits-1:0]] <= in_item.y_coord[COORD_BITS-1:0];
      mem_z[count[IdxBits-1:0]] <= in_item.z_coord[COORD_BITS-1:0];
      mem_p[count[IdxBits-1:0]] <= in_item.piece_id;
    end
    if (cmd.clr_row) begin
      ax <= mem_x[idx_i];
      ay <= mem_y[idx_i];
      az <= mem_z[idx_i];
      ap <= mem_p[idx_i];
      cand <= '0;
      chosen <= '0;
      ncand <= '0;
      kept[idx_i] <= '0;
    end
    if (cmd.cand_step && jr != idx_i && in_range && piece_ok) begin
      cand <= cand | bit_j;
      ncand <= ncand + 1'b1;
    end
    if (cmd.use_cand) kept[idx_i] <= cand;
    if (cmd.sel_clear) have <= 1'b0;
    if (cmd.sel_step && (cand & bit_j) != '0 && (chosen & bit_j) == '0 &&
        (!have || d2 < bestd)) begin
      have <= 1'b1;
      best <= jr;
      bestd <= d2;
    end
    if (cmd.sel_commit) begin
      if (have) begin
        chosen <= chosen | (RowBits'(1) << best);
        kept[idx_i] <= chosen | (RowBits'(1) << best);
      end
    end
    if (cmd.emit_load) emit_r <= kept[idx_i];
    if (cmd.emit_step && (rk & bit_i) != '0) emit_r <= emit_r | bit_j;
  end

  assign stat = {have, ncand};
  // keep only bits above the row
  assign emit_bits = emit_r & ~((bit_i << 1) - RowBits'(1));
endmodule
`default_nettype wire

// ===== rtl/rnpb_ctrl.sv =====
// controller: load counting, build sequencing and row output handshake
`timescale 1ns / 1ps
`default_nettype none
module rnpb_ctrl
  import rnpb_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_final,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [IdxBits-1:0]      out_row,
  output logic                    out_last,
  output logic                    out_ovf,
  input  wire logic [15:0]        radius,
  input  wire logic [CapBits-1:0] cap,
  input  wire dp_stat_t           stat,
  output dp_cmd_t                 cmd,
  output logic [IdxBits:0]        count,
  output logic [IdxBits-1:0]      idx_i,
  output logic [IdxBits-1:0]      idx_j
);
  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_ROW   = 9'b000000010,
    S_CAND  = 9'b000000100,
    S_DEC   = 9'b000001000,
    S_SEL   = 9'b000010000,
    S_COMM  = 9'b000100000,
    S_ELOAD = 9'b001000000,
    S_ESCAN = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state, state_next, row_next;
  logic [IdxBits:0] j_cnt;
  logic [CapBits-1:0] k_cnt;
  logic ovf, empty_build;
  logic in_acc, last_j;
  logic [IdxBits:0] i_next;
  logic cap_ok, sel_done;

  assign in_stall = state != S_LOAD;
  assign in_acc = in_valid && !in_stall;
  assign idx_j = j_cnt[IdxBits-1:0];
  // scans run to address count, one past the last point, as the data is registered behind the address
  assign last_j = j_cnt >= count;
  assign i_next = (IdxBits+1)'(idx_i) + 1'b1;
  assign out_valid = state == S_OUT;
  assign out_row = idx_i;
  assign out_last = i_next == count;
  assign out_ovf = ovf;
  assign cap_ok = cap == '0 || stat.ncand <= (IdxBits+1)'(cap);
  assign sel_done = !stat.have || k_cnt + 1'b1 == cap;
  // all kept rows are built before the first row goes out
  assign row_next = out_last ? S_ELOAD : S_ROW;

  always_comb begin
    cmd = '0;
    cmd.store = in_acc && count < (IdxBits+1)'(MAX_POINTS);
    unique case (state)
      S_LOAD:  ;
      S_ROW:   cmd.clr_row = 1'b1;
      S_CAND:  cmd.cand_step = j_cnt != '0;
      S_DEC:   begin
        cmd.use_cand = cap_ok;
        cmd.sel_clear = 1'b1;
      end
      S_SEL:   cmd.sel_step = j_cnt != '0;
      S_COMM:  begin
        cmd.sel_commit = 1'b1;
        cmd.sel_clear = 1'b1;
      end
      S_ELOAD: cmd.emit_load = 1'b1;
      S_ESCAN: cmd.emit_step = j_cnt != i_next;
      S_OUT:   ;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:  if (in_acc && in_final) state_next = S_ROW;
      S_ROW:   state_next = empty_build ? row_next : S_CAND;
      S_CAND:  if (last_j) state_next = S_DEC;
      S_DEC:   state_next = cap_ok ? row_next : S_SEL;
      S_SEL:   if (last_j) state_next = S_COMM;
      S_COMM:  state_next = sel_done ? row_next : S_SEL;
      S_ELOAD: state_next = (empty_build || out_last) ? S_OUT : S_ESCAN;
      S_ESCAN: if (last_j) state_next = S_OUT;
      S_OUT:   if (!out_stall) state_next = out_last ? S_LOAD : S_ELOAD;
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      ovf <= 1'b0;
      idx_i <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
      empty_build <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_LOAD: if (in_acc) begin
          if (count < (IdxBits+1)'(MAX_POINTS)) count <= count + 1'b1;
          else ovf <= 1'b1;
          idx_i <= '0;
          j_cnt <= '0;
          // rows stay empty with fewer than two points or radius zero
          empty_build <= (count == '0) || radius == '0;
        end
        S_ROW:   begin
          j_cnt <= '0;
          if (empty_build) idx_i <= out_last ? '0 : idx_i + 1'b1;
        end
        S_CAND:  j_cnt <= last_j ? '0 : j_cnt + 1'b1;
        S_DEC:   begin
          j_cnt <= '0;
          k_cnt <= '0;
          if (cap_ok) idx_i <= out_last ? '0 : idx_i + 1'b1;
        end
        S_SEL:   j_cnt <= last_j ? '0 : j_cnt + 1'b1;
        S_COMM:  begin
          k_cnt <= k_cnt + 1'b1;
          j_cnt <= '0;
          if (sel_done) idx_i <= out_last ? '0 : idx_i + 1'b1;
        end
        // emit scan starts at column i+1
        S_ELOAD: j_cnt <= i_next;
        S_ESCAN: j_cnt <= j_cnt + 1'b1;
        S_OUT:   if (!out_stall) begin
          if (out_last) begin
            count <= '0;
            ovf <= 1'b0;
          end else begin
            idx_i <= idx_i + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/radius_neighbour_pair_builder_core.sv =====
// top level: configuration registers, controller and datapath
// Usage: points stream in on the input channel (in_valid/in_stall), one
// transaction per point, taken one per cycle while loading. The point with
// final_point set starts the build; the input stalls until every row of the
// cloud has been delivered. Points past MAX_POINTS are dropped and the rows
// of that cloud carry overflowed.
// Build, for each of the N stored points: a fetch of point i, a candidate
// scan over every stored point (one shared distance unit, stored points
// read through a register), a decision step, and when a partner cap is
// exceeded up to cap selection passes over the points.
// Then the rows go out in index order: per row a load step, a column scan
// over the later columns for the symmetric edges (none for the last row),
// and the output step. Radius zero or a single point skips the scans.
// The output (out_valid/out_stall) holds a row until taken; a stall simply
// freezes the sequencer. Reset (rst, synchronous) empties the cloud and
// clears the registers; point storage needs no clearing. Config is an
// APB-style port, pready high.
`timescale 1ns / 1ps
`default_nettype none
module radius_neighbour_pair_builder_core
  import rnpb_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDefault,
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  logic [15:0] radius;
  logic [CapBits-1:0] max_partners;
  logic across, lane;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [IdxBits:0] count;
  logic [IdxBits-1:0] idx_i, idx_j;
  logic [IdxBits-1:0] out_row;
  logic out_last, out_ovf;
  logic [RowBits-1:0] emit_bits;

  assign pready = 1'b1;
  assign out_data = {out_row, emit_bits, out_last, out_ovf};

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
      max_partners <= '0;
      across <= 1'b0;
      lane <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegRadius:      radius <= pwdata[15:0];
        RegMaxPartners: max_partners <= pwdata[CapBits-1:0];
        RegAcross:      across <= pwdata[0];
        RegLane:        lane <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegRadius:      prdata = {16'd0, radius};
      RegMaxPartners: prdata = {26'd0, max_partners};
      RegAcross:      prdata = {31'd0, across};
      RegLane:        prdata = {31'd0, lane};
      default:        prdata = '0;
    endcase
  end

  rnpb_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall,
    .in_final(in_data.final_point),
    .out_stall, .out_valid,
    .out_row, .out_last, .out_ovf,
    .radius, .cap(max_partners), .stat, .cmd, .count, .idx_i, .idx_j
  );

  rnpb_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk, .cmd, .in_item(in_data), .count, .idx_i, .idx_j,
    .radius, .across, .lane, .stat,
    .emit_bits
  );
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for the radius neighbour pair builder: directed and random clouds checked row by row
`timescale 1ns / 1ps
module tb_top;
  import rnpb_pkg::*;

  localparam int NPTS = 64;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int MAX_SHOWN = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  radius_neighbour_pair_builder_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // model copy of configuration and cloud
  int unsigned cfg_radius = 0;
  int unsigned cfg_cap = 0;
  bit cfg_across = 0;
  bit cfg_lane = 0;
  longint cloud_x [NPTS];
  longint cloud_y [NPTS];
  longint cloud_z [NPTS];
  logic [15:0] cloud_piece [NPTS];
  int cloud_count = 0;
  bit cloud_dropped = 0;
  out_item_t row_q [$];

  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;

  function automatic longint sq_dist(int a, int b);
    longint dx, dy, dz;
    dx = cloud_x[a] - cloud_x[b];
    dy = cloud_y[a] - cloud_y[b];
    dz = cloud_z[a] - cloud_z[b];
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // computes kept partners per point and queues the expected rows
  task automatic build_rows();
    logic [63:0] kept [NPTS];
    logic [63:0] cand, chosen, bits;
    longint r2, d, bestd;
    int ncand, best;
    bit have;
    out_item_t row;
    r2 = longint'(cfg_radius) * longint'(cfg_radius);
    for (int i = 0; i < cloud_count; i++) begin
      cand = '0;
      chosen = '0;
      ncand = 0;
      kept[i] = '0;
      if (cloud_count < 2 || cfg_radius == 0) continue;
      for (int j = 0; j < cloud_count; j++) begin
        if (j == i || sq_dist(i, j) > r2) continue;
        if (cfg_across && (!cfg_lane || cloud_piece[j] == cloud_piece[i])) continue;
        cand[j] = 1'b1;
        ncand++;
      end
      if (cfg_cap == 0 || ncand <= cfg_cap) begin
        kept[i] = cand;
        continue;
      end
      for (int k = 0; k < cfg_cap; k++) begin
        have = 0;
        best = 0;
        bestd = 0;
        for (int j = 0; j < cloud_count; j++) begin
          if (!cand[j] || chosen[j]) continue;
          d = sq_dist(i, j);
          // strict compare leaves ties with the lower index
          if (!have || d < bestd) begin
            have = 1;
            best = j;
            bestd = d;
          end
        end
        if (!have) break;
        chosen[best] = 1'b1;
      end
      kept[i] = chosen;
    end
    for (int i = 0; i < cloud_count; i++) begin
      bits = '0;
      for (int j = i + 1; j < cloud_count; j++)
        if (kept[i][j] || kept[j][i]) bits[j] = 1'b1;
      row.row_index = i[IdxBits-1:0];
      row.partner_bits = bits;
      row.row_last = (i + 1 == cloud_count);
      row.overflowed = cloud_dropped;
      row_q = {row_q, row};
    end
    cloud_count = 0;
    cloud_dropped = 0;
  endtask

  task automatic absorb_point(in_item_t it);
    if (cloud_count < NPTS) begin
      cloud_x[cloud_count] = longint'(it.x_coord);
      cloud_y[cloud_count] = longint'(it.y_coord);
      cloud_z[cloud_count] = longint'(it.z_coord);
      cloud_piece[cloud_count] = it.piece_id;
      cloud_count++;
    end else begin
      cloud_dropped = 1;
    end
    if (it.final_point) build_rows();
  endtask

  // one transaction on the input channel, with bursty gaps
  task automatic send_point(in_item_t it);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    absorb_point(it);
    items_sent++;
    // valid stays up inside a burst so points can go back to back
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic reg_write(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegRadius: cfg_radius = val & 32'hFFFF;
      RegMaxPartners: cfg_cap = val & 32'h3F;
      RegAcross: cfg_across = val[0];
      RegLane: cfg_lane = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
    while (row_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(int unsigned r, int unsigned cap, bit across, bit lane);
    wait_idle();
    reg_write(RegRadius, r);
    reg_write(RegMaxPartners, cap);
    reg_write(RegAcross, across);
    reg_write(RegLane, lane);
  endtask

  function automatic in_item_t mk_point(int x, int y, int z, int piece, bit fin);
    in_item_t it;
    it.x_coord = x[15:0];
    it.y_coord = y[15:0];
    it.z_coord = z[15:0];
    it.piece_id = piece[15:0];
    it.final_point = fin;
    return it;
  endfunction

  task automatic test_reset_config();
    // reset registers give radius zero, so all rows are empty
    send_point(mk_point(0, 0, 0, 0, 0));
    send_point(mk_point(0, 0, 0, 0, 0));
    send_point(mk_point(1, 1, 1, 0, 1));
    // a lone point still gets its row
    set_config(100, 0, 0, 0);
    send_point(mk_point(5, 5, 5, 3, 1));
  endtask

  task automatic test_extremes();
    set_config(65535, 0, 0, 0);
    send_point(mk_point(-32768, -32768, -32768, 16'hFFFF, 0));
    send_point(mk_point(32767, 32767, 32767, 0, 0));
    send_point(mk_point(32767, -32768, 0, 16'hFFFF, 0));
    send_point(mk_point(-32768, 32767, 0, 0, 1));
    // exactly on the radius counts as a partner
    set_config(5, 0, 0, 0);
    send_point(mk_point(0, 0, 0, 1, 0));
    send_point(mk_point(3, 4, 0, 1, 0));
    send_point(mk_point(0, 0, 6, 1, 1));
  endtask

  task automatic test_pieces();
    // across pieces without a lane keeps nothing
    set_config(50, 0, 1, 0);
    send_point(mk_point(0, 0, 0, 1, 0));
    send_point(mk_point(1, 0, 0, 2, 0));
    send_point(mk_point(2, 0, 0, 1, 1));
    set_config(50, 0, 1, 1);
    send_point(mk_point(0, 0, 0, 1, 0));
    send_point(mk_point(1, 0, 0, 2, 0));
    send_point(mk_point(2, 0, 0, 1, 1));
  endtask

  task automatic test_cap_ties();
    // equal distances on both sides of the origin point; cap one keeps only the nearest partner
    set_config(100, 1, 0, 0);
    send_point(mk_point(0, 0, 0, 0, 0));
    send_point(mk_point(10, 0, 0, 0, 0));
    send_point(mk_point(-10, 0, 0, 0, 0));
    send_point(mk_point(0, 3, 0, 0, 0));
    send_point(mk_point(0, 0, -10, 0, 1));
    set_config(100, 63, 0, 0);
    send_point(mk_point(0, 0, 0, 0, 0));
    send_point(mk_point(1, 0, 0, 0, 1));
  endtask

  task automatic test_overflow();
    // 66 points: the last two are dropped, the final one still builds
    set_config(40, 2, 0, 0);
    for (int n = 0; n < 66; n++)
      send_point(mk_point($urandom_range(0, 60), $urandom_range(0, 60),
                          $urandom_range(0, 60), $urandom, n == 65));
    // the next cloud starts clean
    send_point(mk_point(0, 0, 0, 0, 0));
    send_point(mk_point(1, 1, 1, 0, 1));
  endtask

  task automatic test_random_clouds();
    int size, spread, bx, by, bz, piece0, r, cap;
    while (items_sent < 200) begin
      case ($urandom_range(0, 7))
        0: r = 0;
        1: r = 65535;
        2: r = $urandom_range(0, 65535);
        default: r = $urandom_range(1, 3000);
      endcase
      size = $urandom_range(1, 12);
      cap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, size);
      set_config(r, cap, $urandom_range(0, 1), $urandom_range(0, 1));
      stall_mode = $urandom_range(0, 3);
      spread = (r == 0 || r > 16000) ? 16000 : r;
      bx = $urandom_range(0, 65535) - 32768;
      by = $urandom_range(0, 65535) - 32768;
      bz = $urandom_range(0, 65535) - 32768;
      piece0 = $urandom;
      for (int n = 0; n < size; n++) begin
        if ($urandom_range(0, 4) == 0)
          send_point(mk_point($urandom, $urandom, $urandom, $urandom, n == size - 1));
        else
          send_point(mk_point(bx + $urandom_range(0, 2 * spread) - spread,
                              by + $urandom_range(0, 2 * spread) - spread,
                              bz + $urandom_range(0, 2 * spread) - spread,
                              piece0 ^ $urandom_range(0, 1), n == size - 1));
      end
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= (cycles % 7) < 3;
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // out_stall changes only at rising edges, so the negedge view is the accept view
  always @(negedge clk) begin
    out_item_t exp_row;
    if (!rst && out_valid && !out_stall) begin
      if (row_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected row: index %0d bits %h last %b ovf %b",
                   out_data.row_index, out_data.partner_bits,
                   out_data.row_last, out_data.overflowed);
      end else begin
        exp_row = row_q.pop_front();
        if (out_data !== exp_row) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("row mismatch: exp idx %0d bits %h last %b ovf %b, got idx %0d bits %h last %b ovf %b",
                     exp_row.row_index, exp_row.partner_bits, exp_row.row_last,
                     exp_row.overflowed, out_data.row_index, out_data.partner_bits,
                     out_data.row_last, out_data.overflowed);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    stall_mode = 1;
    test_reset_config();
    stall_mode = 0;
    test_extremes();
    stall_mode = 3;
    test_pieces();
    stall_mode = 2;
    test_cap_ties();
    stall_mode = 1;
    test_overflow();
    test_random_clouds();
    wait_idle();
    repeat (300) @(posedge clk);
    if (errors == 0 && row_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
